FILE: rtl/fk_dbnc_pkg.sv
// ----------------------------------------------------------------------------
// fk_dbnc_pkg
// Types and constants shared by the four-key debounce block and its checker.
// ----------------------------------------------------------------------------
package fk_dbnc_pkg;

	localparam int FLAG_W = 4;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int PIN_KEYS = 4;

	// port pins of the active-low keys
	localparam int PORT_BIT_MEM = 0;
	localparam int PORT_BIT_TEST = 1;
	localparam int PORT_BIT_SET = 4;

	typedef enum logic [1:0] {
		OP_SCAN     = 2'd0,
		OP_CLEAR    = 2'd1,
		OP_ACK_REL  = 2'd2,
		OP_ACK_HOLD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_CONFIRM  = 2'd2,
		PH_RELEASE  = 2'd3
	} key_phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DITHER     = 3'd0,
		CFG_HOLD_MEM   = 3'd1,
		CFG_HOLD_TEST  = 3'd2,
		CFG_HOLD_SET   = 3'd3,
		CFG_HOLD_MODE  = 3'd4,
		CFG_REPEAT_EN  = 3'd5,
		CFG_REPEAT_INT = 3'd6
	} cfg_reg_t;

	localparam logic [7:0] DITHER_RST = 8'd2;
	localparam logic [7:0] HOLD_LIMIT_RST = 8'd100;
	localparam logic [3:0] REPEAT_EN_RST = 4'd0;
	localparam logic [7:0] REPEAT_INT_RST = 8'd10;

endpackage

FILE: rtl/four_key_debounce_hold_repeat.sv
// ----------------------------------------------------------------------------
// four_key_debounce_hold_repeat
// Debounce, long-hold and auto-repeat detection for four keys with sticky
// press, hold, repeat and release flags.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_stall   | opcode, port_bits, mode_pin, ack_mask
//  out     | out_valid / out_stall | press_flags, hold_flags, repeat_flags,
//          |                       | release_flags
//  cfg     | cfg_wr_en             | cfg_index, cfg_data
//
//  one item per cycle while in_stall is low; its result shows in the cycle after the transfer
//  the flag registers are the result register, so in_stall is only raised
//  while a result waits and out_stall is high
//  arst_n clears key state and flags and loads the register defaults
//  keys beyond four have no pin and stay idle, so they carry no state
// ----------------------------------------------------------------------------
module four_key_debounce_hold_repeat #(
	parameter int NUM_KEYS = 4,
	parameter int COUNT_MAX = 254
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [fk_dbnc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fk_dbnc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            opcode,
	input  logic [7:0]                            port_bits,
	input  logic                                  mode_pin,
	input  logic [3:0]                            ack_mask,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [3:0]                            press_flags,
	output logic [3:0]                            hold_flags,
	output logic [3:0]                            repeat_flags,
	output logic [3:0]                            release_flags
);
	import fk_dbnc_pkg::*;

	localparam int ActKeys = (NUM_KEYS < PIN_KEYS) ? NUM_KEYS : PIN_KEYS;

	logic [7:0]       dither_q;
	logic [7:0]       hold_limit_q [PIN_KEYS];
	logic [3:0]       repeat_en_q;
	logic [7:0]       repeat_int_q;

	key_phase_t       phase_q [ActKeys];
	key_phase_t       phase_d [ActKeys];
	logic [7:0]       count_q [ActKeys];
	logic [7:0]       count_d [ActKeys];
	logic [ActKeys-1:0] latch_q;
	logic [ActKeys-1:0] latch_d;

	logic [FLAG_W-1:0] press_q, hold_q, repeat_q, release_q;
	logic [FLAG_W-1:0] press_d, hold_d, repeat_d, release_d;
	logic              out_valid_q;

	logic [PIN_KEYS-1:0] key_on;
	logic [7:0]          count_inc [ActKeys];
	logic [7:0]          count_sat [ActKeys];
	logic [7:0]          count_rld [ActKeys];
	logic                in_xfer;

	assign in_stall = out_valid_q & out_stall;
	assign in_xfer = in_valid & ~in_stall;

	assign out_valid = out_valid_q;
	assign press_flags = press_q;
	assign hold_flags = hold_q;
	assign repeat_flags = repeat_q;
	assign release_flags = release_q;

	// keys are active low on the pins
	assign key_on = {~mode_pin, ~port_bits[PORT_BIT_SET], ~port_bits[PORT_BIT_TEST],
		~port_bits[PORT_BIT_MEM]};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_q <= DITHER_RST;
			for (int i = 0; i < PIN_KEYS; i++) begin
				hold_limit_q[i] <= HOLD_LIMIT_RST;
			end
			repeat_en_q <= REPEAT_EN_RST;
			repeat_int_q <= REPEAT_INT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_DITHER:     dither_q <= cfg_data;
				CFG_HOLD_MEM:   hold_limit_q[0] <= cfg_data;
				CFG_HOLD_TEST:  hold_limit_q[1] <= cfg_data;
				CFG_HOLD_SET:   hold_limit_q[2] <= cfg_data;
				CFG_HOLD_MODE:  hold_limit_q[3] <= cfg_data;
				CFG_REPEAT_EN:  repeat_en_q <= cfg_data[3:0];
				CFG_REPEAT_INT: repeat_int_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-key counter arithmetic
	always_comb begin
		for (int k = 0; k < ActKeys; k++) begin
			count_inc[k] = count_q[k] + 8'd1;
			count_sat[k] = (count_q[k] < 8'(COUNT_MAX)) ? count_inc[k] : count_q[k];
			count_rld[k] = hold_limit_q[k] - repeat_int_q;
		end
	end

	// next state of the key machines and flag words
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		latch_d = latch_q;
		press_d = press_q;
		hold_d = hold_q;
		repeat_d = repeat_q;
		release_d = release_q;
		unique case (op_t'(opcode))
			OP_SCAN: begin
				for (int k = 0; k < ActKeys; k++) begin
					unique case (phase_q[k])
						PH_IDLE: begin
							if (key_on[k]) begin
								count_d[k] = 8'd0;
								latch_d[k] = 1'b1;
								phase_d[k] = PH_DEBOUNCE;
							end
						end
						PH_DEBOUNCE: begin
							if (key_on[k] == latch_q[k]) begin
								count_d[k] = count_inc[k];
								if (count_inc[k] > dither_q) begin
									phase_d[k] = PH_CONFIRM;
									if (key_on[k]) press_d[k] = 1'b1;
								end
							end else begin
								phase_d[k] = PH_IDLE;
							end
						end
						PH_CONFIRM: begin
							if (key_on[k] == latch_q[k]) begin
								count_d[k] = count_sat[k];
								if (count_sat[k] > hold_limit_q[k]) begin
									if (key_on[k]) hold_d[k] = 1'b1;
									if (repeat_en_q[k]) begin
										if (key_on[k]) repeat_d[k] = 1'b1;
										count_d[k] = count_rld[k];
									end
								end
							end else begin
								phase_d[k] = PH_RELEASE;
							end
						end
						PH_RELEASE: begin
							if (!key_on[k]) begin
								if (latch_q[k]) begin
									press_d[k] = 1'b0;
									hold_d[k] = 1'b0;
									repeat_d[k] = 1'b0;
									release_d[k] = 1'b1;
								end
								phase_d[k] = PH_IDLE;
							end
						end
					endcase
				end
			end
			OP_CLEAR: begin
				// hold counts survive a clear
				press_d = '0;
				hold_d = '0;
				repeat_d = '0;
				release_d = '0;
				latch_d = '0;
				for (int k = 0; k < ActKeys; k++) begin
					phase_d[k] = PH_IDLE;
				end
			end
			OP_ACK_REL:  release_d = release_q & ~ack_mask;
			OP_ACK_HOLD: hold_d = hold_q & ~ack_mask;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ActKeys; k++) begin
				phase_q[k] <= PH_IDLE;
				count_q[k] <= 8'd0;
			end
			latch_q <= '0;
			press_q <= '0;
			hold_q <= '0;
			repeat_q <= '0;
			release_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				phase_q <= phase_d;
				count_q <= count_d;
				latch_q <= latch_d;
				press_q <= press_d;
				hold_q <= hold_d;
				repeat_q <= repeat_d;
				release_q <= release_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/fk_dbnc_checker.sv
// ----------------------------------------------------------------------------
// fk_dbnc_checker
// Port-level checks for the four-key debounce block, bound to its top level.
// ----------------------------------------------------------------------------
module fk_dbnc_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic [1:0]                            opcode,
	input logic [3:0]                            ack_mask,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [3:0]                            press_flags,
	input logic [3:0]                            hold_flags,
	input logic [3:0]                            repeat_flags,
	input logic [3:0]                            release_flags
);
	import fk_dbnc_pkg::*;

	logic in_xfer;
	logic [15:0] flags_all;

	assign in_xfer = in_valid & ~in_stall;
	assign flags_all = {press_flags, hold_flags, repeat_flags, release_flags};

	// input side only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> out_valid)
		else $error("accepted item produced no result");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && opcode == OP_CLEAR) |=> (flags_all == 16'd0))
		else $error("flags not cleared by clear-all");

	a_ack_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && opcode == OP_ACK_HOLD) |=> ((hold_flags & $past(ack_mask)) == 4'd0))
		else $error("acknowledged hold flags still set");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(flags_all)))
		else $error("stalled result changed");

endmodule

bind four_key_debounce_hold_repeat fk_dbnc_checker u_checker (.*);

FILE: sim/four_key_debounce_hold_repeat_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_key_debounce_hold_repeat_tb
// Self-checking bench for the four-key debounce block. Each transfer is also
// fed to a behavioral copy of the key machines. The result that comes back is
// compared against that copy, or against expected flags from the table for
// typed rows. Stimulus starts with a short table of corner cases and goes on
// to long random key presses under changing register settings. Random stalls
// and gaps are put on both channels.
module four_key_debounce_hold_repeat_tb;
	import fk_dbnc_pkg::*;

	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 3;
	localparam int ITEMS_PER_SET = 100;
	localparam int SETS_PER_MODE = 3;
	localparam int MAX_REPORTS = 10;
	localparam logic [7:0] COUNT_SAT = 8'd254;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	typedef struct packed {
		logic [3:0] press;
		logic [3:0] hold;
		logic [3:0] rpt;
		logic [3:0] rel;
	} flag_set_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] port;
		logic       mode;
		logic [3:0] ack;
	} key_item_t;

	typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [7:0]             reg_val;
		key_item_t              item;
		logic                   typed;
		flag_set_t              want;
	} dir_row_t;

	localparam flag_set_t NO_FLAGS = '0;
	localparam key_item_t NO_ITEM = '{OP_SCAN, 8'hFF, 1'b1, 4'h0};
	localparam int N_DIR = 33;

	localparam dir_row_t DIR_TAB [N_DIR] = '{
		// nothing can be set right after reset
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'hFF, 1'b1, 4'h0}, 1'b1, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'hEC, 1'b0, 4'h0}, 1'b1, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_ACK_REL, 8'h00, 1'b1, 4'hF}, 1'b1, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_ACK_HOLD, 8'hFF, 1'b0, 4'hF}, 1'b1, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_CLEAR, 8'h00, 1'b0, 4'h0}, 1'b1, NO_FLAGS},
		// zero debounce, limits at both ends, repeat reload that wraps
		'{ROW_REG, CFG_DITHER, 8'h00, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_REG, CFG_HOLD_MEM, 8'h00, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_REG, CFG_HOLD_TEST, 8'hFF, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_REG, CFG_HOLD_SET, 8'h01, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_REG, CFG_HOLD_MODE, 8'hFE, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_REG, CFG_REPEAT_EN, 8'h05, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_REG, CFG_REPEAT_INT, 8'h01, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_REG, CFG_SPARE, 8'hFF, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h00, 1'b0, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h00, 1'b0, 4'hA}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h00, 1'b0, 4'h5}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h00, 1'b0, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h00, 1'b0, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_ACK_HOLD, 8'h00, 1'b0, 4'h1}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'hFF, 1'b1, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'hFF, 1'b1, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_ACK_REL, 8'hFF, 1'b1, 4'h5}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_ACK_REL, 8'hFF, 1'b1, 4'hF}, 1'b0, NO_FLAGS},
		// set key bounces back to idle in debounce
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'hEF, 1'b1, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'hFF, 1'b1, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'hEF, 1'b1, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_CLEAR, 8'hFF, 1'b1, 4'h0}, 1'b1, NO_FLAGS},
		// debounce limit at its top never confirms
		'{ROW_REG, CFG_DITHER, 8'hFF, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_REG, CFG_REPEAT_INT, 8'h00, NO_ITEM, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h6C, 1'b0, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h6C, 1'b0, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h6C, 1'b0, 4'h0}, 1'b0, NO_FLAGS},
		'{ROW_ITEM, CFG_DITHER, 8'h00, '{OP_SCAN, 8'h6C, 1'b0, 4'h0}, 1'b0, NO_FLAGS}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           opcode;
	logic [7:0]           port_bits;
	logic                 mode_pin;
	logic [3:0]           ack_mask;
	logic                 out_valid;
	logic                 out_stall;
	logic [3:0]           press_flags;
	logic [3:0]           hold_flags;
	logic [3:0]           repeat_flags;
	logic [3:0]           release_flags;

	// behavioral copy of the key machines and registers
	key_phase_t key_phase [PIN_KEYS];
	logic [7:0] key_count [PIN_KEYS];
	logic       key_latched [PIN_KEYS];
	flag_set_t  key_flags;
	logic [7:0] dither_lim;
	logic [7:0] hold_lim [PIN_KEYS];
	logic [3:0] rpt_en;
	logic [7:0] rpt_gap;

	flag_set_t  pending_flags [$];
	int         flag_mismatches = 0;
	int         stray_flags = 0;
	int         cycle_cnt = 0;
	int         send_idle_pct;
	int         recv_idle_pct;
	logic [3:0] held_keys;

	four_key_debounce_hold_repeat dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.port_bits(port_bits),
		.mode_pin(mode_pin),
		.ack_mask(ack_mask),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.press_flags(press_flags),
		.hold_flags(hold_flags),
		.repeat_flags(repeat_flags),
		.release_flags(release_flags)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic clear_key_model();
		for (int k = 0; k < PIN_KEYS; k++) begin
			key_phase[k] = PH_IDLE;
			key_count[k] = 8'd0;
			key_latched[k] = 1'b0;
			hold_lim[k] = HOLD_LIMIT_RST;
		end
		key_flags = NO_FLAGS;
		dither_lim = DITHER_RST;
		rpt_en = REPEAT_EN_RST;
		rpt_gap = REPEAT_INT_RST;
	endtask

	function automatic flag_set_t advance_keys(key_item_t it);
		logic [3:0] pressed;
		logic [7:0] lim;
		pressed = {~it.mode, ~it.port[PORT_BIT_SET], ~it.port[PORT_BIT_TEST],
			~it.port[PORT_BIT_MEM]};
		case (it.op)
		OP_SCAN: begin
			for (int k = 0; k < PIN_KEYS; k++) begin
				case (key_phase[k])
				PH_IDLE: begin
					if (pressed[k]) begin
						key_count[k] = 8'd0;
						key_latched[k] = 1'b1;
						key_phase[k] = PH_DEBOUNCE;
					end
				end
				PH_DEBOUNCE: begin
					if (pressed[k] == key_latched[k]) begin
						// wraps, so a limit of 255 never confirms
						key_count[k] = key_count[k] + 8'd1;
						if (key_count[k] > dither_lim) begin
							key_phase[k] = PH_CONFIRM;
							if (pressed[k]) key_flags.press[k] = 1'b1;
						end
					end else begin
						key_phase[k] = PH_IDLE;
					end
				end
				PH_CONFIRM: begin
					if (pressed[k] == key_latched[k]) begin
						lim = hold_lim[k];
						if (key_count[k] < COUNT_SAT) key_count[k] = key_count[k] + 8'd1;
						if (key_count[k] > lim) begin
							if (pressed[k]) key_flags.hold[k] = 1'b1;
							if (rpt_en[k]) begin
								if (pressed[k]) key_flags.rpt[k] = 1'b1;
								key_count[k] = lim - rpt_gap;
							end
						end
					end else begin
						key_phase[k] = PH_RELEASE;
					end
				end
				default: begin
					if (!pressed[k]) begin
						if (key_latched[k]) begin
							key_flags.press[k] = 1'b0;
							key_flags.hold[k] = 1'b0;
							key_flags.rpt[k] = 1'b0;
							key_flags.rel[k] = 1'b1;
						end
						key_phase[k] = PH_IDLE;
					end
				end
				endcase
			end
		end
		OP_CLEAR: begin
			// hold counts survive a clear
			key_flags = NO_FLAGS;
			for (int k = 0; k < PIN_KEYS; k++) begin
				key_latched[k] = 1'b0;
				key_phase[k] = PH_IDLE;
			end
		end
		OP_ACK_REL: key_flags.rel = key_flags.rel & ~it.ack;
		default: key_flags.hold = key_flags.hold & ~it.ack;
		endcase
		return key_flags;
	endfunction

	function automatic key_item_t make_key_item();
		key_item_t it;
		logic [31:0] bits;
		logic [3:0] seen;
		int r;
		bits = $urandom;
		r = $urandom_range(0, 99);
		it.port = bits[7:0];
		it.mode = bits[8];
		it.ack = bits[15:12];
		if (r < 4) it.op = OP_CLEAR;
		else if (r < 10) it.op = OP_ACK_REL;
		else if (r < 16) it.op = OP_ACK_HOLD;
		else it.op = OP_SCAN;
		if (it.op == OP_SCAN) begin
			if ($urandom_range(0, 11) == 0) held_keys = bits[19:16];
			seen = held_keys;
			// a glitch that flips a single key in this scan item
			if ($urandom_range(0, 99) < 6) seen[bits[21:20]] = ~seen[bits[21:20]];
			it.port[PORT_BIT_MEM] = ~seen[0];
			it.port[PORT_BIT_TEST] = ~seen[1];
			it.port[PORT_BIT_SET] = ~seen[2];
			it.mode = ~seen[3];
		end
		return it;
	endfunction

	function automatic logic [7:0] pick_hold_limit();
		int r;
		logic [31:0] v;
		r = $urandom_range(0, 9);
		if (r == 0) v = 0;
		else if (r == 1) v = $urandom_range(240, 255);
		else v = $urandom_range(0, 15);
		return v[7:0];
	endfunction

	task automatic send_item(key_item_t it, logic typed, flag_set_t want);
		flag_set_t predicted;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= it.op;
		port_bits <= it.port;
		mode_pin <= it.mode;
		ack_mask <= it.ack;
		do @(posedge clk); while (in_stall);
		predicted = advance_keys(it);
		pending_flags.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_flags.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		CFG_DITHER: dither_lim = val;
		CFG_HOLD_MEM: hold_lim[0] = val;
		CFG_HOLD_TEST: hold_lim[1] = val;
		CFG_HOLD_SET: hold_lim[2] = val;
		CFG_HOLD_MODE: hold_lim[3] = val;
		CFG_REPEAT_EN: rpt_en = val[3:0];
		CFG_REPEAT_INT: rpt_gap = val;
		default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic close_regs();
		cfg_wr_en <= 1'b0;
	endtask

	task automatic shuffle_regs();
		logic [31:0] v;
		wait_drained();
		v = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
		write_reg(CFG_DITHER, v[7:0]);
		write_reg(CFG_HOLD_MEM, pick_hold_limit());
		write_reg(CFG_HOLD_TEST, pick_hold_limit());
		write_reg(CFG_HOLD_SET, pick_hold_limit());
		write_reg(CFG_HOLD_MODE, pick_hold_limit());
		v = $urandom;
		write_reg(CFG_REPEAT_EN, {4'h0, v[3:0]});
		v = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 255);
		write_reg(CFG_REPEAT_INT, v[7:0]);
		if ($urandom_range(0, 1) == 0) begin
			v = $urandom;
			write_reg(CFG_SPARE, v[7:0]);
		end
		close_regs();
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin : check_flags
		flag_set_t got;
		flag_set_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{press_flags, hold_flags, repeat_flags, release_flags};
			if (pending_flags.size() == 0) begin
				stray_flags++;
				if (stray_flags + flag_mismatches <= MAX_REPORTS)
					$display("cycle %0d: result transfer with nothing outstanding", cycle_cnt);
			end else begin
				want = pending_flags.pop_front();
				if (got.press !== want.press || got.hold !== want.hold ||
						got.rpt !== want.rpt || got.rel !== want.rel) begin
					flag_mismatches++;
					if (stray_flags + flag_mismatches <= MAX_REPORTS)
						$display({"cycle %0d: flags press/hold/repeat/release expected ",
							"%h/%h/%h/%h, got %h/%h/%h/%h"}, cycle_cnt,
							want.press, want.hold, want.rpt, want.rel,
							got.press, got.hold, got.rpt, got.rel);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		bit writing_regs;
		writing_regs = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_SCAN;
		port_bits = 8'hFF;
		mode_pin = 1'b1;
		ack_mask = 4'h0;
		out_stall = 1'b0;
		held_keys = 4'h0;
		send_idle_pct = 31;
		recv_idle_pct = 79;
		clear_key_model();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++) begin
			if (DIR_TAB[i].kind == ROW_REG) begin
				if (!writing_regs) begin
					wait_drained();
					writing_regs = 1'b1;
				end
				write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].reg_val);
			end else begin
				if (writing_regs) begin
					close_regs();
					writing_regs = 1'b0;
				end
				send_item(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].want);
			end
		end

		for (int m = 0; m < 3; m++) begin
			case (m)
			0: begin
				send_idle_pct = 31;
				recv_idle_pct = 79;
			end
			1: begin
				send_idle_pct = 79;
				recv_idle_pct = 31;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			endcase
			for (int s = 0; s < SETS_PER_MODE; s++) begin
				shuffle_regs();
				for (int n = 0; n < ITEMS_PER_SET; n++) begin
					// hold off mid-set until every outstanding transfer is back
					if (n == ITEMS_PER_SET / 2) wait_drained();
					send_item(make_key_item(), 1'b0, NO_FLAGS);
				end
			end
		end

		wait_drained();
		if (flag_mismatches == 0 && stray_flags == 0 && pending_flags.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
